// ----- hw/rtl/bitmap_buffer_allocator_unit_macros.svh -----
// Assertion macros for the bitmap buffer allocator checker.
// Expects clk and rst in the scope of each use.
`ifndef BITMAP_BUFFER_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BUFFER_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define BBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// Next-cycle implication, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

// ----- hw/rtl/bba_pkg.sv -----
// Shared constants for the bitmap buffer allocator.
// No dependencies; used by the top level and its checker.
package bba_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int ENTRY_W    = 6;   // width of entry_index
  localparam int FREED_W    = 7;   // width of freed_entry
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NONE_FREE = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

endpackage

// ----- hw/rtl/bitmap_buffer_allocator_unit.sv -----
// Bitmap buffer allocator: next-fit allocate/free over a pool of buffers.
// Depends on bba_pkg.
//
// Each request is either an allocate or a free. Requests are taken one per
// cycle unless a response waits unread, and each yields exactly one response
// in the cycle after it is taken. The rate of one request per cycle is set by
// the combinational rotating find-first over the free bitmap, between the bitmap
// flops and the response register. An allocate starts at the cursor word, takes the
// first word (wrapping) with a free bit, grabs its highest free bit and
// leaves the cursor there; with nothing free it answers status none-free.
// A free sets the entry's bit and moves the cursor to its word; an index at
// or above ENTRIES answers status out-of-range and changes nothing. After
// reset every entry is free and the cursor is on word 0; no clearing pass.
// The response register is refilled in the same cycle it is taken, so the
// input stalls only while a response sits unread.
module bitmap_buffer_allocator_unit
  import bba_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [6:0] freed_entry, [7] zero
  input  logic [0:0]            s_axis_tuser,  // [0] req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] granted, [6:1] entry_index,
                                               // [8:7] status, [15:9] zero
);

  localparam int NUM_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int TOTAL     = NUM_WORDS * WORD_BITS;
  localparam int CW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int IW        = ($clog2(TOTAL) > ENTRY_W) ? $clog2(TOTAL) : ENTRY_W;

  // Bits at and above ENTRIES are never set.
  localparam logic [TOTAL-1:0] RESET_MAP = ~({TOTAL{1'b1}} << ENTRIES);

  // State: flat bitmap, word-major, so entry i lives at bit i.
  logic [TOTAL-1:0] bitmap;
  logic [TOTAL-1:0] bitmap_next;
  logic [CW-1:0]    cursor;
  logic [CW-1:0]    cursor_next;

  // Response register
  logic               granted;
  logic [ENTRY_W-1:0] entry_index;
  logic [1:0]         status;
  logic               granted_next;
  logic [ENTRY_W-1:0] entry_index_next;
  logic [1:0]         status_next;

  logic               req_type;
  logic [FREED_W-1:0] freed_entry;
  logic               accept;

  // Search
  logic [NUM_WORDS-1:0] word_nz;
  logic [NUM_WORDS-1:0] below_mask;
  logic [NUM_WORDS-1:0] from_cursor;
  logic [NUM_WORDS-1:0] cand;
  logic [CW-1:0]        pick_word;
  logic [WORD_BITS-1:0] sel_word;
  logic [BW-1:0]        pick_bit;
  logic [IW-1:0]        alloc_pos;
  logic [CW-1:0]        free_word;
  logic                 in_range;

  assign req_type    = s_axis_tuser[0];
  assign freed_entry = s_axis_tdata[FREED_W-1:0];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Which words hold a free entry
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_nz[w] = |bitmap[w*WORD_BITS +: WORD_BITS];
    end
  end

  // First non-empty word at or after the cursor, else first overall (wrap)
  assign below_mask  = (NUM_WORDS'(1) << cursor) - NUM_WORDS'(1);
  assign from_cursor = word_nz & ~below_mask;
  assign cand        = (|from_cursor) ? from_cursor : word_nz;

  always_comb begin
    pick_word = '0;
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        pick_word = CW'(w);
      end
    end
  end

  // Pull out the chosen word, then its highest set bit
  always_comb begin
    sel_word = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (pick_word == CW'(w)) begin
        sel_word = sel_word | bitmap[w*WORD_BITS +: WORD_BITS];
      end
    end
  end

  always_comb begin
    pick_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (sel_word[b]) begin
        pick_bit = BW'(b);
      end
    end
  end

  assign alloc_pos = IW'(pick_word) * IW'(WORD_BITS) + IW'(pick_bit);

  // Word of a freed entry: last word whose base is not above the index
  always_comb begin
    free_word = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (32'(freed_entry) >= 32'(w * WORD_BITS)) begin
        free_word = CW'(w);
      end
    end
  end

  assign in_range = 32'(freed_entry) < 32'(ENTRIES);

  always_comb begin
    bitmap_next      = bitmap;
    cursor_next      = cursor;
    granted_next     = 1'b0;
    entry_index_next = '0;
    status_next      = STATUS_OK;
    case (req_type)
      REQ_ALLOC: begin
        if (|word_nz) begin
          bitmap_next      = bitmap & ~(TOTAL'(1) << alloc_pos);
          cursor_next      = pick_word;
          granted_next     = 1'b1;
          entry_index_next = alloc_pos[ENTRY_W-1:0];
        end else begin
          status_next = STATUS_NONE_FREE;
        end
      end
      REQ_FREE: begin
        if (in_range) begin
          bitmap_next = bitmap | (TOTAL'(1) << freed_entry);
          cursor_next = free_word;
        end else begin
          status_next = STATUS_RANGE;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap        <= RESET_MAP;
      cursor        <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      bitmap        <= bitmap_next;
      cursor        <= cursor_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      granted     <= granted_next;
      entry_index <= entry_index_next;
      status      <= status_next;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - ENTRY_W - 3){1'b0}}, status, entry_index, granted};

endmodule

// ----- hw/rtl/bba_checker.sv -----
// Port-level checker for the bitmap buffer allocator, bound to the top level.
// Depends on bba_pkg and bitmap_buffer_allocator_unit_macros.svh.
`include "bitmap_buffer_allocator_unit_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled response holds
  `BBA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Input is open exactly when the response slot is free or draining
  `BBA_ASSERT_SAME(a_ready_rule, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // Every taken request shows a response next cycle
  `BBA_ASSERT_NEXT(a_resp_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

  // A grant is ok; no grant means a zero index; no unused status code
  `BBA_ASSERT_SAME(a_resp_shape, m_axis_tvalid, (m_axis_tdata[8:7] != 2'd3) && (!m_axis_tdata[0] || m_axis_tdata[8:7] == STATUS_OK) && (m_axis_tdata[0] || m_axis_tdata[6:1] == 6'd0))

endmodule

bind bitmap_buffer_allocator_unit bba_checker u_bba_checker (.*);
